### hdl/absm_pkg.sv
package absm_pkg;

    localparam int unsigned SLOTS = 2;

    typedef enum logic [2:0] {
        REQ_INIT        = 3'd0,
        REQ_SELECT      = 3'd1,
        REQ_STATUS      = 3'd2,
        REQ_MARK_OK     = 3'd3,
        REQ_MARK_ACTIVE = 3'd4,
        REQ_MARK_DEAD   = 3'd5
    } req_t;

    typedef enum logic [0:0] {
        CFG_MAX_PRIORITY = 1'd0,
        CFG_MAX_TRIES    = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] prio;
        logic [7:0] tries;
        logic       succ;
    } slot_t;

    typedef struct packed {
        logic fallback;
        logic pick;
    } choice_t;

    localparam logic [7:0] DEF_PRIO_A   = 8'd15;
    localparam logic [7:0] DEF_PRIO_B   = 8'd14;
    localparam logic [7:0] DEF_TRIES    = 8'd7;
    localparam logic [7:0] RST_MAX_PRIO = 8'd15;
    localparam logic [7:0] RST_MAX_TRY  = 8'd7;

    function automatic slot_t default_slot(input logic k);
        slot_t s;
        s.prio  = k ? DEF_PRIO_B : DEF_PRIO_A;
        s.tries = DEF_TRIES;
        s.succ  = 1'b0;
        return s;
    endfunction

    function automatic logic bootable(input slot_t s);
        return (s.prio != 8'd0) && (s.succ || (s.tries != 8'd0));
    endfunction

    function automatic slot_t tidy(input slot_t s);
        slot_t r;
        r = s;
        if (r.prio != 8'd0)
        begin
            if ((r.tries == 8'd0 && !r.succ) || (r.tries != 8'd0 && r.succ))
            begin
                r.prio = 8'd0;
            end
        end
        if (r.prio == 8'd0)
        begin
            r.tries = 8'd0;
            r.succ  = 1'b0;
        end
        return r;
    endfunction

    function automatic choice_t choose(input slot_t a, input slot_t b, input logic last);
        choice_t c;
        logic    ba;
        logic    bb;
        ba = bootable(a);
        bb = bootable(b);
        c.fallback = 1'b0;
        if (ba && bb)
        begin
            c.pick = (b.prio > a.prio);
        end
        else if (ba)
        begin
            c.pick = 1'b0;
        end
        else if (bb)
        begin
            c.pick = 1'b1;
        end
        else
        begin
            c.pick     = last;
            c.fallback = 1'b1;
        end
        return c;
    endfunction

endpackage

### hdl/ab_boot_slot_manager.sv
// A/B boot slot manager.
// Input channel: in_valid, in_stall (driven here), req_type, target_slot.
// A command is a transfer at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall (driven by the receiver) and the result
// fields: chosen slot, fallback flag, both slots' priority, tries, successful
// and bootable flags, and the last booted slot.
// Every command yields exactly one result, valid in the cycle after its transfer.
// The slot state and the result register update together at the transfer, so a
// new command is taken every cycle while the receiver does not stall: throughput is one command per clock.
// While the receiver stalls, the held result stays on the outputs and in_stall
// is raised only while a result is waiting and out_stall is high.
// Configuration: cfg_we, cfg_index, cfg_data write max_priority (index 0) or
// max_tries (index 1) at the clock edge; write only while idle.
// Reset (rst_n low, asynchronous): slots return to A priority 15, B priority
// 14, seven tries each, not successful, last boot A; max_priority 15,
// max_tries 7; no result pending.
module ab_boot_slot_manager
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic       target_slot,

    output logic       out_valid,
    input  logic       out_stall,
    output logic       chosen_slot,
    output logic       fallback_used,
    output logic [7:0] a_priority,
    output logic [7:0] a_tries,
    output logic       a_successful,
    output logic       a_bootable,
    output logic [7:0] b_priority,
    output logic [7:0] b_tries,
    output logic       b_successful,
    output logic       b_bootable,
    output logic       last_boot_slot
);

    absm_pkg::slot_t   slot_reg [absm_pkg::SLOTS];
    absm_pkg::slot_t   slot_next [absm_pkg::SLOTS];
    logic              last_reg;
    logic              last_next;
    logic [7:0]        max_prio_reg;
    logic [7:0]        max_tries_reg;
    logic              out_valid_reg;
    absm_pkg::choice_t choice;
    logic              in_xfer;

    absm_pkg::slot_t   res_a_reg;
    absm_pkg::slot_t   res_b_reg;
    absm_pkg::choice_t res_choice_reg;
    logic              res_a_boot_reg;
    logic              res_b_boot_reg;
    logic              res_last_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        absm_pkg::slot_t tidy_a;
        absm_pkg::slot_t tidy_b;
        logic            t;
        logic            o;
        logic [7:0]      demote;
        tidy_a    = absm_pkg::tidy(slot_reg[0]);
        tidy_b    = absm_pkg::tidy(slot_reg[1]);
        t         = target_slot;
        o         = ~target_slot;
        demote    = (max_prio_reg == 8'd0) ? 8'd0 : max_prio_reg - 8'd1;
        slot_next = slot_reg;
        last_next = last_reg;
        choice    = '0;
        case (absm_pkg::req_t'(req_type))
            absm_pkg::REQ_INIT:
            begin
                slot_next[0] = absm_pkg::default_slot(1'b0);
                slot_next[1] = absm_pkg::default_slot(1'b1);
                last_next    = 1'b0;
                choice       = absm_pkg::choose(slot_next[0], slot_next[1], last_next);
            end
            absm_pkg::REQ_SELECT:
            begin
                slot_next[0] = tidy_a;
                slot_next[1] = tidy_b;
                choice       = absm_pkg::choose(tidy_a, tidy_b, last_reg);
                if (!slot_next[choice.pick].succ && slot_next[choice.pick].tries != 8'd0)
                begin
                    slot_next[choice.pick].tries = slot_next[choice.pick].tries - 8'd1;
                end
                last_next = choice.pick;
            end
            absm_pkg::REQ_MARK_OK:
            begin
                slot_next[t].tries = 8'd0;
                slot_next[t].succ  = 1'b1;
                if (slot_reg[t].prio == 8'd0)
                begin
                    slot_next[t].prio = max_prio_reg;
                end
                choice = absm_pkg::choose(slot_next[0], slot_next[1], last_reg);
            end
            absm_pkg::REQ_MARK_ACTIVE:
            begin
                slot_next[t].prio  = max_prio_reg;
                slot_next[t].tries = max_tries_reg;
                slot_next[t].succ  = 1'b0;
                if (slot_reg[o].prio >= max_prio_reg)
                begin
                    slot_next[o].prio = demote;
                end
                choice = absm_pkg::choose(slot_next[0], slot_next[1], last_reg);
            end
            absm_pkg::REQ_MARK_DEAD:
            begin
                slot_next[t] = '0;
                choice       = absm_pkg::choose(slot_next[0], slot_next[1], last_reg);
            end
            default:
            begin
                choice = absm_pkg::choose(slot_reg[0], slot_reg[1], last_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg[0]   <= absm_pkg::default_slot(1'b0);
            slot_reg[1]   <= absm_pkg::default_slot(1'b1);
            last_reg      <= 1'b0;
            max_prio_reg  <= absm_pkg::RST_MAX_PRIO;
            max_tries_reg <= absm_pkg::RST_MAX_TRY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (absm_pkg::cfg_idx_t'(cfg_index))
                    absm_pkg::CFG_MAX_PRIORITY: max_prio_reg  <= cfg_data;
                    absm_pkg::CFG_MAX_TRIES:    max_tries_reg <= cfg_data;
                    default:                    max_tries_reg <= max_tries_reg;
                endcase
            end
            if (in_xfer)
            begin
                slot_reg      <= slot_next;
                last_reg      <= last_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_a_reg      <= slot_next[0];
            res_b_reg      <= slot_next[1];
            res_choice_reg <= choice;
            res_a_boot_reg <= absm_pkg::bootable(slot_next[0]);
            res_b_boot_reg <= absm_pkg::bootable(slot_next[1]);
            res_last_reg   <= last_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign chosen_slot    = res_choice_reg.pick;
    assign fallback_used  = res_choice_reg.fallback;
    assign a_priority     = res_a_reg.prio;
    assign a_tries        = res_a_reg.tries;
    assign a_successful   = res_a_reg.succ;
    assign a_bootable     = res_a_boot_reg;
    assign b_priority     = res_b_reg.prio;
    assign b_tries        = res_b_reg.tries;
    assign b_successful   = res_b_reg.succ;
    assign b_bootable     = res_b_boot_reg;
    assign last_boot_slot = res_last_reg;

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_SPARE_6     = 3'd6;
    localparam logic [2:0] REQ_SPARE_7     = 3'd7;
    localparam logic [7:0] INIT_PRIO_A     = 8'd15;
    localparam logic [7:0] INIT_PRIO_B     = 8'd14;
    localparam logic [7:0] INIT_TRIES      = 8'd7;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         QUIET_LIMIT     = 2000;

    typedef struct packed {
        logic       pick;
        logic       fell_back;
        logic [7:0] a_prio;
        logic [7:0] a_tries;
        logic       a_succ;
        logic       a_boot;
        logic [7:0] b_prio;
        logic [7:0] b_tries;
        logic       b_succ;
        logic       b_boot;
        logic       last;
    } boot_report_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [2:0] req_type;
    logic       target_slot;
    logic       out_valid;
    logic       out_stall;
    logic       chosen_slot;
    logic       fallback_used;
    logic [7:0] a_priority;
    logic [7:0] a_tries;
    logic       a_successful;
    logic       a_bootable;
    logic [7:0] b_priority;
    logic [7:0] b_tries;
    logic       b_successful;
    logic       b_bootable;
    logic       last_boot_slot;

    absm_pkg::slot_t slots [2];
    logic            last_slot;
    logic [7:0]      lim_prio;
    logic [7:0]      lim_tries;
    boot_report_t    expected_reports [$];

    bit gaps_on      = 1'b1;
    bit stalls_on    = 1'b1;
    bit hold_off_req = 1'b0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    ab_boot_slot_manager dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void load_boot_defaults();
        slots[0].prio  = INIT_PRIO_A;
        slots[0].tries = INIT_TRIES;
        slots[0].succ  = 1'b0;
        slots[1].prio  = INIT_PRIO_B;
        slots[1].tries = INIT_TRIES;
        slots[1].succ  = 1'b0;
        last_slot      = 1'b0;
    endfunction

    function automatic logic slot_ready(input absm_pkg::slot_t s);
        return (s.prio != 8'd0) && (s.succ || (s.tries != 8'd0));
    endfunction

    function automatic absm_pkg::slot_t normalize_slot(input absm_pkg::slot_t s);
        absm_pkg::slot_t r;
        r = s;
        if (r.prio != 8'd0)
        begin
            if (r.tries == 8'd0 && !r.succ)
            begin
                r.prio = 8'd0;
            end
            else if (r.tries != 8'd0 && r.succ)
            begin
                r.prio = 8'd0;
            end
        end
        if (r.prio == 8'd0)
        begin
            r.tries = 8'd0;
            r.succ  = 1'b0;
        end
        return r;
    endfunction

    function automatic absm_pkg::choice_t boot_choice();
        absm_pkg::choice_t c;
        logic              ra;
        logic              rb;
        ra = slot_ready(slots[0]);
        rb = slot_ready(slots[1]);
        c.fallback = 1'b0;
        if (ra && rb)
        begin
            c.pick = (slots[1].prio > slots[0].prio) ? 1'b1 : 1'b0;
        end
        else if (ra || rb)
        begin
            c.pick = rb;
        end
        else
        begin
            c.pick     = last_slot;
            c.fallback = 1'b1;
        end
        return c;
    endfunction

    function automatic boot_report_t advance_slots(input logic [2:0] op, input logic t);
        boot_report_t      rep;
        absm_pkg::choice_t c;
        logic              o;
        logic              picked;
        o      = ~t;
        picked = 1'b0;
        case (op)
            absm_pkg::REQ_INIT:
            begin
                load_boot_defaults();
            end
            absm_pkg::REQ_SELECT:
            begin
                slots[0] = normalize_slot(slots[0]);
                slots[1] = normalize_slot(slots[1]);
                c        = boot_choice();
                picked   = 1'b1;
                if (!slots[c.pick].succ && slots[c.pick].tries != 8'd0)
                begin
                    slots[c.pick].tries = slots[c.pick].tries - 8'd1;
                end
                last_slot = c.pick;
            end
            absm_pkg::REQ_MARK_OK:
            begin
                slots[t].tries = 8'd0;
                slots[t].succ  = 1'b1;
                if (slots[t].prio == 8'd0)
                begin
                    slots[t].prio = lim_prio;
                end
            end
            absm_pkg::REQ_MARK_ACTIVE:
            begin
                slots[t].prio  = lim_prio;
                slots[t].tries = lim_tries;
                slots[t].succ  = 1'b0;
                if (slots[o].prio >= lim_prio)
                begin
                    slots[o].prio = (lim_prio != 8'd0) ? lim_prio - 8'd1 : 8'd0;
                end
            end
            absm_pkg::REQ_MARK_DEAD:
            begin
                slots[t] = '0;
            end
            default:
            begin
            end
        endcase
        if (!picked)
        begin
            c = boot_choice();
        end
        rep.pick      = c.pick;
        rep.fell_back = c.fallback;
        rep.a_prio    = slots[0].prio;
        rep.a_tries   = slots[0].tries;
        rep.a_succ    = slots[0].succ;
        rep.a_boot    = slot_ready(slots[0]);
        rep.b_prio    = slots[1].prio;
        rep.b_tries   = slots[1].tries;
        rep.b_succ    = slots[1].succ;
        rep.b_boot    = slot_ready(slots[1]);
        rep.last      = last_slot;
        return rep;
    endfunction

    function automatic string show_report(input boot_report_t r);
        return $sformatf({"pick=%0d fb=%0d A(p=%0d t=%0d s=%0d b=%0d) ",
                          "B(p=%0d t=%0d s=%0d b=%0d) last=%0d"},
                         r.pick, r.fell_back, r.a_prio, r.a_tries, r.a_succ, r.a_boot,
                         r.b_prio, r.b_tries, r.b_succ, r.b_boot, r.last);
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic which);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= op;
        target_slot <= which;
        do
            @(posedge clk);
        while (in_stall);
        expected_reports.push_back(advance_slots(op, which));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input absm_pkg::cfg_idx_t idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == absm_pkg::CFG_MAX_PRIORITY)
        begin
            lim_prio = val;
        end
        else
        begin
            lim_tries = val;
        end
    endtask

    task automatic set_limits(input logic [7:0] prio, input logic [7:0] tries);
        wait_idle();
        write_reg(absm_pkg::CFG_MAX_PRIORITY, prio);
        write_reg(absm_pkg::CFG_MAX_TRIES, tries);
    endtask

    // mostly activate / boot / confirm-or-kill flows, the rest loose commands
    task automatic boot_traffic(input int count);
        int   sent;
        int   boots;
        logic t;
        sent = 0;
        while (sent < count)
        begin
            t = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 6)
            begin
                send_cmd(absm_pkg::REQ_MARK_ACTIVE, t);
                boots = $urandom_range(1, 9);
                repeat (boots) send_cmd(absm_pkg::REQ_SELECT, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) != 0)
                begin
                    send_cmd(absm_pkg::REQ_MARK_OK, last_slot);
                end
                else
                begin
                    send_cmd(absm_pkg::REQ_MARK_DEAD, 1'($urandom_range(0, 1)));
                end
                sent += boots + 2;
            end
            else
            begin
                send_cmd(3'($urandom_range(0, 7)), t);
                sent++;
            end
        end
    endtask

    task automatic test_reset_state();
        send_cmd(absm_pkg::REQ_STATUS, 1'b0);
        send_cmd(absm_pkg::REQ_STATUS, 1'b1);
        send_cmd(REQ_SPARE_6, 1'b1);
        send_cmd(REQ_SPARE_7, 1'b0);
    endtask

    task automatic test_commands();
        send_cmd(absm_pkg::REQ_SELECT, 1'b1);
        send_cmd(absm_pkg::REQ_MARK_OK, 1'b0);
        send_cmd(absm_pkg::REQ_SELECT, 1'b0);
        send_cmd(absm_pkg::REQ_MARK_ACTIVE, 1'b1);
        send_cmd(absm_pkg::REQ_SELECT, 1'b0);
        send_cmd(absm_pkg::REQ_MARK_DEAD, 1'b1);
        send_cmd(absm_pkg::REQ_MARK_DEAD, 1'b0);
        send_cmd(absm_pkg::REQ_STATUS, 1'b0);
        send_cmd(absm_pkg::REQ_MARK_OK, 1'b1);
        send_cmd(absm_pkg::REQ_INIT, 1'b1);
    endtask

    task automatic test_try_exhaustion();
        set_limits(8'd15, 8'd1);
        send_cmd(absm_pkg::REQ_MARK_ACTIVE, 1'b0);
        send_cmd(absm_pkg::REQ_SELECT, 1'b0);
        send_cmd(absm_pkg::REQ_SELECT, 1'b0);
    endtask

    task automatic test_priority_tie();
        send_cmd(absm_pkg::REQ_INIT, 1'b0);
        send_cmd(absm_pkg::REQ_MARK_DEAD, 1'b1);
        send_cmd(absm_pkg::REQ_MARK_OK, 1'b1);
    endtask

    task automatic test_zero_max_priority();
        set_limits(8'd0, 8'd0);
        send_cmd(absm_pkg::REQ_MARK_ACTIVE, 1'b0);
        send_cmd(absm_pkg::REQ_MARK_OK, 1'b0);
        send_cmd(absm_pkg::REQ_INIT, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_limits(8'd255, 8'd255);
        send_cmd(absm_pkg::REQ_MARK_ACTIVE, 1'b1);
        send_cmd(absm_pkg::REQ_SELECT, 1'b0);
    endtask

    task automatic test_backpressure();
        bit keep;
        keep         = gaps_on;
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        repeat (30) send_cmd(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        gaps_on = keep;
    endtask

    task automatic test_random_traffic();
        set_limits(8'd1, 8'd1);
        boot_traffic(100);
        set_limits(8'd255, 8'd255);
        boot_traffic(60);
        set_limits(8'd0, 8'd0);
        boot_traffic(40);
        repeat (3)
        begin
            set_limits(8'($urandom_range(1, 255)), 8'($urandom_range(1, 9)));
            boot_traffic(100);
        end
    endtask

    task automatic test_steady_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_limits(8'd15, 8'd7);
        boot_traffic(100);
    endtask

    initial
    begin
        lim_prio  = 8'd15;
        lim_tries = 8'd7;
        load_boot_defaults();
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= absm_pkg::CFG_MAX_PRIORITY;
        cfg_data    <= 8'd0;
        in_valid    <= 1'b0;
        req_type    <= absm_pkg::REQ_STATUS;
        target_slot <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_commands();
        test_try_exhaustion();
        test_priority_tie();
        test_zero_max_priority();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ab_boot_slot_manager test passed");
        end
        else
        begin
            $display("ab_boot_slot_manager test failed");
        end
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int burst;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        boot_report_t seen;
        boot_report_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen = {chosen_slot, fallback_used, a_priority, a_tries, a_successful, a_bootable,
                    b_priority, b_tries, b_successful, b_bootable, last_boot_slot};
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected transfer: %s", show_report(seen));
                end
            end
            else
            begin
                want = expected_reports.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", show_report(want));
                        $display("  actual   %s", show_report(seen));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ab_boot_slot_manager test failed");
            $finish;
        end
    end

endmodule
